/* sv/table_cell_grid_placement_assert.svh */
// ----------------------------------------------------------------------------
// Table cell grid placement: assertion macros
// Shared concurrent assertion forms, clocked by clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TABLE_CELL_GRID_PLACEMENT_ASSERT_SVH
`define TABLE_CELL_GRID_PLACEMENT_ASSERT_SVH

// same-cycle implication
`define TCGP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TCGP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/tcgp_pkg.sv */
// ----------------------------------------------------------------------------
// Table cell grid placement package
// Widths, limits, command codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package tcgp_pkg;

    localparam int MAX_COLUMNS_DEF = 64;

    localparam int CMD_W   = 2;
    localparam int CSPAN_W = 10;
    localparam int RSPAN_W = 16;
    localparam int CFG_W   = 16;

    localparam logic [CSPAN_W-1:0] COL_SPAN_LIMIT = 10'd1000;
    localparam logic [RSPAN_W-1:0] ROW_SPAN_LIMIT = 16'd65534;

    localparam logic [CMD_W-1:0] CMD_CELL      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ROW_END   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TABLE_END = 2'd2;

    // column sweep operations
    localparam logic [1:0] SW_MAX = 2'd0;   // raise held rows to the cell span
    localparam logic [1:0] SW_DEC = 2'd1;   // count held rows down by one
    localparam logic [1:0] SW_CLR = 2'd2;   // clear and find the last held column

    typedef struct packed {
        logic       accept;
        logic       skip_step;
        logic       place;
        logic       full;
        logic       row_end;
        logic       sweep_init;
        logic [1:0] sweep_op;
        logic       sweep_run;
        logic       table_fin;
        logic       load_out;
    } tcgp_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             cursor_full;
        logic             rd_nonzero;
        logic             rspan_multi;
        logic             sweep_done;
        logic             out_free;
    } tcgp_stat_t;

endpackage

`default_nettype wire

/* sv/tcgp_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcgp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* sv/tcgp_ctrl.sv */
// ----------------------------------------------------------------------------
// Table cell grid placement controller
// Sequences decode, column skip, placement, column sweeps and result load.
// ----------------------------------------------------------------------------
`default_nettype none

module tcgp_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire tcgp_pkg::tcgp_stat_t stat,
    output tcgp_pkg::tcgp_cmd_t      cmd
);

    localparam logic [3:0] S_INIT     = 4'd0;
    localparam logic [3:0] S_SW_INIT  = 4'd1;
    localparam logic [3:0] S_IDLE     = 4'd2;
    localparam logic [3:0] S_DECODE   = 4'd3;
    localparam logic [3:0] S_SKIP_RD  = 4'd4;
    localparam logic [3:0] S_SKIP_CHK = 4'd5;
    localparam logic [3:0] S_PLACE    = 4'd6;
    localparam logic [3:0] S_SW_CELL  = 4'd7;
    localparam logic [3:0] S_SW_ROW   = 4'd8;
    localparam logic [3:0] S_SW_TAB   = 4'd9;
    localparam logic [3:0] S_RESULT   = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_INIT:
            begin
                cmd.sweep_init = 1'b1;
                cmd.sweep_op   = tcgp_pkg::SW_CLR;
                state_next     = S_SW_INIT;
            end
            S_SW_INIT:
            begin
                cmd.sweep_run = 1'b1;
                if (stat.sweep_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.cmd)
                    tcgp_pkg::CMD_CELL:
                    begin
                        state_next = S_SKIP_RD;
                    end
                    tcgp_pkg::CMD_ROW_END:
                    begin
                        cmd.sweep_init = 1'b1;
                        cmd.sweep_op   = tcgp_pkg::SW_DEC;
                        cmd.row_end    = 1'b1;
                        state_next     = S_SW_ROW;
                    end
                    tcgp_pkg::CMD_TABLE_END:
                    begin
                        cmd.sweep_init = 1'b1;
                        cmd.sweep_op   = tcgp_pkg::SW_CLR;
                        state_next     = S_SW_TAB;
                    end
                    default:
                    begin
                        // unused command: drop without a result
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SKIP_RD:
            begin
                state_next = stat.cursor_full ? S_PLACE : S_SKIP_CHK;
            end
            S_SKIP_CHK:
            begin
                if (stat.rd_nonzero)
                begin
                    cmd.skip_step = 1'b1;
                    state_next    = S_SKIP_RD;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                if (stat.cursor_full)
                begin
                    cmd.full   = 1'b1;
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.place  = 1'b1;
                    state_next = stat.rspan_multi ? S_SW_CELL : S_RESULT;
                end
            end
            S_SW_CELL, S_SW_ROW:
            begin
                cmd.sweep_run = 1'b1;
                if (stat.sweep_done)
                begin
                    state_next = S_RESULT;
                end
            end
            S_SW_TAB:
            begin
                cmd.sweep_run = 1'b1;
                if (stat.sweep_done)
                begin
                    cmd.table_fin = 1'b1;
                    state_next    = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* sv/tcgp_dp.sv */
// ----------------------------------------------------------------------------
// Table cell grid placement datapath
// Span normalization, column cursor, held-row memory with its sweep engine,
// and the result and output registers.
// ----------------------------------------------------------------------------
`default_nettype none
`include "table_cell_grid_placement_assert.svh"

module tcgp_dp #(
    parameter int MAX_COLUMNS = tcgp_pkg::MAX_COLUMNS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [tcgp_pkg::CFG_W-1:0]    cfg_wdata,
    input  wire logic [tcgp_pkg::CMD_W-1:0]    command,
    input  wire logic [tcgp_pkg::CSPAN_W-1:0]  cell_cols,
    input  wire logic [tcgp_pkg::RSPAN_W-1:0]  cell_rows,
    input  wire logic                          out_ready,
    input  wire tcgp_pkg::tcgp_cmd_t           cmd,
    output tcgp_pkg::tcgp_stat_t               stat,
    output logic                               out_valid,
    output logic [5:0]                         start_column,
    output logic [6:0]                         used_col_span,
    output logic [15:0]                        used_row_span,
    output logic [6:0]                         column_count,
    output logic                               overflow
);

    localparam int CW   = $clog2(MAX_COLUMNS + 1);
    localparam int AW   = $clog2(MAX_COLUMNS);
    localparam int CMPW = (CW > tcgp_pkg::CSPAN_W) ? CW : tcgp_pkg::CSPAN_W;
    localparam int RW   = tcgp_pkg::RSPAN_W;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_COLUMNS);

    // configuration and latched item
    logic [RW-1:0]               row_total_reg, row_total_next;
    logic [tcgp_pkg::CMD_W-1:0]  cmd_reg, cmd_next;
    logic [tcgp_pkg::CSPAN_W-1:0] cspan_reg, cspan_next;
    logic [RW-1:0]               rspan_reg, rspan_next;

    // table state
    logic [CW-1:0] cursor_reg, cursor_next;
    logic [CW-1:0] cols_used_reg, cols_used_next;
    logic [RW-1:0] row_index_reg, row_index_next;

    // sweep engine
    logic [CW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] sw_end_reg, sw_end_next;
    logic [1:0]    sw_op_reg, sw_op_next;
    logic          wb_valid_reg, wb_valid_next;
    logic [AW-1:0] wb_addr_reg, wb_addr_next;
    logic [CW-1:0] total_reg, total_next;

    // staged result
    logic [CW-1:0] res_start_reg, res_start_next;
    logic [CW-1:0] res_used_reg, res_used_next;
    logic [RW-1:0] res_rspan_reg, res_rspan_next;
    logic [CW-1:0] res_count_reg, res_count_next;
    logic          res_ovf_reg, res_ovf_next;

    // output register
    logic          out_valid_reg, out_valid_next;
    logic [5:0]    out_start_reg, out_start_next;
    logic [6:0]    out_used_reg, out_used_next;
    logic [15:0]   out_rspan_reg, out_rspan_next;
    logic [6:0]    out_count_reg, out_count_next;
    logic          out_ovf_reg, out_ovf_next;

    // memory port
    logic          ram_we;
    logic [AW-1:0] ram_raddr;
    logic [RW-1:0] ram_wdata;
    logic [RW-1:0] ram_rdata;

    // combinational helpers
    logic [RW-1:0]               rs_sat, remaining, rs_zero, rs_fix, rs_clamp;
    logic [tcgp_pkg::CSPAN_W-1:0] cs_norm;
    logic [CW-1:0]               room, used, new_cursor, wb_next1;
    logic [CMPW-1:0]             cs_ext, room_ext;
    logic                        clip;
    logic [31:0]                 res_start_w, res_used_w, res_count_w;

    tcgp_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_COLUMNS)
    ) u_held_rows (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wb_addr_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // row and column span rules at accept
    always_comb
    begin
        rs_sat    = (cell_rows > tcgp_pkg::ROW_SPAN_LIMIT) ? tcgp_pkg::ROW_SPAN_LIMIT
                                                          : cell_rows;
        remaining = (row_index_reg < row_total_reg) ? (row_total_reg - row_index_reg)
                                                    : '0;
        rs_zero   = (remaining != '0) ? remaining : RW'(1);
        rs_fix    = (rs_sat == '0) ? rs_zero : rs_sat;
        rs_clamp  = ((remaining != '0) && (rs_fix > remaining)) ? remaining : rs_fix;
        if (cell_cols == '0)
        begin
            cs_norm = tcgp_pkg::CSPAN_W'(1);
        end
        else if (cell_cols > tcgp_pkg::COL_SPAN_LIMIT)
        begin
            cs_norm = tcgp_pkg::COL_SPAN_LIMIT;
        end
        else
        begin
            cs_norm = cell_cols;
        end
    end

    // column clipping at placement
    assign room       = MAX_C - cursor_reg;
    assign cs_ext     = CMPW'(cspan_reg);
    assign room_ext   = CMPW'(room);
    assign clip       = (cs_ext > room_ext);
    assign used       = clip ? room : cs_ext[CW-1:0];
    assign new_cursor = cursor_reg + used;
    assign wb_next1   = CW'(wb_addr_reg) + CW'(1);

    assign ram_raddr = cmd.sweep_run ? ptr_reg[AW-1:0] : cursor_reg[AW-1:0];
    assign ram_we    = cmd.sweep_run && wb_valid_reg;

    always_comb
    begin
        case (sw_op_reg)
            tcgp_pkg::SW_MAX: ram_wdata = (ram_rdata < rspan_reg) ? rspan_reg : ram_rdata;
            tcgp_pkg::SW_DEC: ram_wdata = (ram_rdata != '0) ? (ram_rdata - RW'(1)) : '0;
            default:          ram_wdata = '0;
        endcase
    end

    assign res_start_w = 32'(res_start_reg);
    assign res_used_w  = 32'(res_used_reg);
    assign res_count_w = 32'(res_count_reg);

    always_comb
    begin
        row_total_next = cfg_we ? cfg_wdata : row_total_reg;
        cmd_next       = cmd_reg;
        cspan_next     = cspan_reg;
        rspan_next     = rspan_reg;
        cursor_next    = cursor_reg;
        cols_used_next = cols_used_reg;
        row_index_next = row_index_reg;
        ptr_next       = ptr_reg;
        sw_end_next    = sw_end_reg;
        sw_op_next     = sw_op_reg;
        wb_valid_next  = wb_valid_reg;
        wb_addr_next   = wb_addr_reg;
        total_next     = total_reg;
        res_start_next = res_start_reg;
        res_used_next  = res_used_reg;
        res_rspan_next = res_rspan_reg;
        res_count_next = res_count_reg;
        res_ovf_next   = res_ovf_reg;
        out_valid_next = out_valid_reg;
        out_start_next = out_start_reg;
        out_used_next  = out_used_reg;
        out_rspan_next = out_rspan_reg;
        out_count_next = out_count_reg;
        out_ovf_next   = out_ovf_reg;

        if (cmd.accept)
        begin
            cmd_next   = command;
            cspan_next = cs_norm;
            rspan_next = rs_clamp;
        end

        if (cmd.skip_step)
        begin
            cursor_next = cursor_reg + CW'(1);
        end

        if (cmd.full)
        begin
            res_start_next = '0;
            res_used_next  = '0;
            res_rspan_next = rspan_reg;
            res_count_next = cols_used_reg;
            res_ovf_next   = 1'b1;
        end

        if (cmd.place)
        begin
            cursor_next    = new_cursor;
            cols_used_next = (cols_used_reg < new_cursor) ? new_cursor : cols_used_reg;
            ptr_next       = cursor_reg;
            sw_end_next    = new_cursor;
            sw_op_next     = tcgp_pkg::SW_MAX;
            wb_valid_next  = 1'b0;
            res_start_next = cursor_reg;
            res_used_next  = used;
            res_rspan_next = rspan_reg;
            res_count_next = (cols_used_reg < new_cursor) ? new_cursor : cols_used_reg;
            res_ovf_next   = clip;
        end

        if (cmd.row_end)
        begin
            cursor_next    = '0;
            row_index_next = (row_index_reg != '1) ? (row_index_reg + RW'(1))
                                                   : row_index_reg;
            res_start_next = '0;
            res_used_next  = '0;
            res_rspan_next = '0;
            res_count_next = cols_used_reg;
            res_ovf_next   = 1'b0;
        end

        if (cmd.sweep_init)
        begin
            ptr_next      = '0;
            sw_end_next   = MAX_C;
            sw_op_next    = cmd.sweep_op;
            wb_valid_next = 1'b0;
            total_next    = cols_used_reg;
        end

        // read one column ahead, write back the column read last cycle
        if (cmd.sweep_run)
        begin
            if (ptr_reg != sw_end_reg)
            begin
                ptr_next      = ptr_reg + CW'(1);
                wb_valid_next = 1'b1;
                wb_addr_next  = ptr_reg[AW-1:0];
            end
            else
            begin
                wb_valid_next = 1'b0;
            end
            if (wb_valid_reg && (sw_op_reg == tcgp_pkg::SW_CLR) && (ram_rdata != '0)
                && (total_reg < wb_next1))
            begin
                total_next = wb_next1;
            end
        end

        if (cmd.table_fin)
        begin
            res_start_next = '0;
            res_used_next  = '0;
            res_rspan_next = '0;
            res_count_next = total_reg;
            res_ovf_next   = 1'b0;
            cursor_next    = '0;
            cols_used_next = '0;
            row_index_next = '0;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
            out_start_next = res_start_w[5:0];
            out_used_next  = res_used_w[6:0];
            out_rspan_next = res_rspan_reg;
            out_count_next = res_count_w[6:0];
            out_ovf_next   = res_ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_total_reg <= '0;
            cursor_reg    <= '0;
            cols_used_reg <= '0;
            row_index_reg <= '0;
            ptr_reg       <= '0;
            sw_end_reg    <= '0;
            sw_op_reg     <= tcgp_pkg::SW_CLR;
            wb_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            row_total_reg <= row_total_next;
            cursor_reg    <= cursor_next;
            cols_used_reg <= cols_used_next;
            row_index_reg <= row_index_next;
            ptr_reg       <= ptr_next;
            sw_end_reg    <= sw_end_next;
            sw_op_reg     <= sw_op_next;
            wb_valid_reg  <= wb_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        cspan_reg     <= cspan_next;
        rspan_reg     <= rspan_next;
        wb_addr_reg   <= wb_addr_next;
        total_reg     <= total_next;
        res_start_reg <= res_start_next;
        res_used_reg  <= res_used_next;
        res_rspan_reg <= res_rspan_next;
        res_count_reg <= res_count_next;
        res_ovf_reg   <= res_ovf_next;
        out_start_reg <= out_start_next;
        out_used_reg  <= out_used_next;
        out_rspan_reg <= out_rspan_next;
        out_count_reg <= out_count_next;
        out_ovf_reg   <= out_ovf_next;
    end

    always_comb
    begin
        stat.cmd         = cmd_reg;
        stat.cursor_full = (cursor_reg == MAX_C);
        stat.rd_nonzero  = (ram_rdata != '0);
        stat.rspan_multi = (rspan_reg > RW'(1));
        stat.sweep_done  = (ptr_reg == sw_end_reg) && !wb_valid_reg;
        stat.out_free    = !out_valid_reg || out_ready;
    end

    assign out_valid     = out_valid_reg;
    assign start_column  = out_start_reg;
    assign used_col_span = out_used_reg;
    assign used_row_span = out_rspan_reg;
    assign column_count  = out_count_reg;
    assign overflow      = out_ovf_reg;

    `TCGP_ASSERT_IMP(a_cursor_range, 1'b1, cursor_reg <= MAX_C,
        "cursor past column limit")
    `TCGP_ASSERT_IMP(a_cursor_used, 1'b1, cursor_reg <= cols_used_reg,
        "cursor past used columns")
    `TCGP_ASSERT_IMP(a_wb_in_range, ram_we, CW'(wb_addr_reg) < sw_end_reg,
        "write past sweep end")
    `TCGP_ASSERT_IMP(a_no_overwrite, cmd.load_out, !out_valid_reg || out_ready,
        "pending result lost")
    `TCGP_ASSERT_NXT(a_table_clear, cmd.table_fin,
        cursor_reg == '0 && cols_used_reg == '0 && row_index_reg == '0,
        "table state not cleared")

endmodule

`default_nettype wire

/* sv/table_cell_grid_placement.sv */
// Cell: decode, then a read and a check per held column skipped, then placement;
//   a row span above 1 adds a sweep over the columns covered.
// End of row and end of table: a sweep over all MAX_COLUMNS columns.
// Throughput: one transaction at a time; the next accept can come in the cycle
//   after the result loads, while that result waits in the output register.
// Reset: a clearing pass zeroes the memory; no input is taken during it.
// ----------------------------------------------------------------------------
// Table cell grid placement
// Places table cells on a column grid, holding columns for spanning cells.
// ----------------------------------------------------------------------------
`default_nettype none

module table_cell_grid_placement #(
    parameter int MAX_COLUMNS = tcgp_pkg::MAX_COLUMNS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [tcgp_pkg::CFG_W-1:0]    cfg_wdata,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [tcgp_pkg::CMD_W-1:0]    command,
    input  wire logic [tcgp_pkg::CSPAN_W-1:0]  cell_cols,
    input  wire logic [tcgp_pkg::RSPAN_W-1:0]  cell_rows,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [5:0]                         start_column,
    output logic [6:0]                         used_col_span,
    output logic [15:0]                        used_row_span,
    output logic [6:0]                         column_count,
    output logic                               overflow
);

    tcgp_pkg::tcgp_cmd_t  cmd;
    tcgp_pkg::tcgp_stat_t stat;

    tcgp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tcgp_dp #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .command       (command),
        .cell_cols     (cell_cols),
        .cell_rows     (cell_rows),
        .out_ready     (out_ready),
        .cmd           (cmd),
        .stat          (stat),
        .out_valid     (out_valid),
        .start_column  (start_column),
        .used_col_span (used_col_span),
        .used_row_span (used_row_span),
        .column_count  (column_count),
        .overflow      (overflow)
    );

endmodule

`default_nettype wire

/* test/table_cell_grid_placement_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Table cell grid placement checker
// Watches the configuration port and both channels, predicts the placement
// of every accepted transaction and compares each result field by field.
// ----------------------------------------------------------------------------

module table_cell_grid_placement_checker #(
    parameter int NCOLS = tcgp_pkg::MAX_COLUMNS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  command,
    input  logic [9:0]  cell_cols,
    input  logic [15:0] cell_rows,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [5:0]  start_column,
    input  logic [6:0]  used_col_span,
    input  logic [15:0] used_row_span,
    input  logic [6:0]  column_count,
    input  logic        overflow,
    output int          mismatches,
    output int          outstanding
);
    import tcgp_pkg::*;

    typedef struct packed {
        logic [5:0]  start;
        logic [6:0]  cspan;
        logic [15:0] rspan;
        logic [6:0]  count;
        logic        ovf;
    } placement_t;

    logic [15:0] row_total;
    logic [15:0] held_rows [NCOLS];
    int          cursor;
    int          cols_used;
    int          row_idx;
    int          fail_count;
    placement_t  placement_q [$];

    function automatic void clear_grid();
        for (int k = 0; k < NCOLS; k++)
        begin
            held_rows[k] = '0;
        end
        cursor    = 0;
        cols_used = 0;
        row_idx   = 0;
    endfunction

    // Returns 1 when the transaction produces a result.
    function automatic bit place_transaction(input logic [1:0] cmd, input logic [9:0] cs_in,
                                             input logic [15:0] rs_in, output placement_t res);
        int cspan;
        int rspan;
        int remaining;
        int used;
        int total;
        bit ovf;
        res   = '0;
        ovf   = 1'b0;
        cspan = cs_in;
        rspan = rs_in;
        case (cmd)
            CMD_CELL:
            begin
                if (cspan == 0) cspan = 1;
                if (cspan > COL_SPAN_LIMIT) cspan = COL_SPAN_LIMIT;
                if (rspan > ROW_SPAN_LIMIT) rspan = ROW_SPAN_LIMIT;
                while (cursor < NCOLS && held_rows[cursor] != 0) cursor++;
                remaining = (row_idx < row_total) ? row_total - row_idx : 0;
                if (rspan == 0) rspan = (remaining > 0) ? remaining : 1;
                if (remaining > 0 && rspan > remaining) rspan = remaining;
                res.rspan = 16'(rspan);
                if (cursor >= NCOLS)
                begin
                    // table full: nothing is held
                    res.count = 7'(cols_used);
                    res.ovf   = 1'b1;
                    return 1'b1;
                end
                used = cspan;
                if (used > NCOLS - cursor)
                begin
                    used = NCOLS - cursor;
                    ovf  = 1'b1;
                end
                if (rspan > 1)
                begin
                    for (int k = cursor; k < cursor + used; k++)
                    begin
                        if (held_rows[k] < rspan) held_rows[k] = 16'(rspan);
                    end
                end
                res.start = 6'(cursor);
                res.cspan = 7'(used);
                res.ovf   = ovf;
                cursor    = cursor + used;
                if (cols_used < cursor) cols_used = cursor;
                res.count = 7'(cols_used);
                return 1'b1;
            end
            CMD_ROW_END:
            begin
                for (int k = 0; k < NCOLS; k++)
                begin
                    if (held_rows[k] != 0) held_rows[k] = held_rows[k] - 16'd1;
                end
                cursor = 0;
                if (row_idx < 16'hFFFF) row_idx++;
                res.count = 7'(cols_used);
                return 1'b1;
            end
            CMD_TABLE_END:
            begin
                // held columns past the widest row still count
                total = cols_used;
                for (int k = 0; k < NCOLS; k++)
                begin
                    if (held_rows[k] != 0 && total < k + 1) total = k + 1;
                end
                res.count = 7'(total);
                clear_grid();
                return 1'b1;
            end
            default:
            begin
                return 1'b0;
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        placement_t want;
        placement_t fresh;
        if (!rst_n)
        begin
            clear_grid();
            row_total = '0;
            placement_q.delete();
            fail_count = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we) row_total = cfg_wdata;
            if (out_valid && out_ready)
            begin
                if (placement_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"%0t: result with nothing pending: start=%0d cspan=%0d",
                                  " rspan=%0d count=%0d ovf=%0d"},
                                 $time, start_column, used_col_span, used_row_span,
                                 column_count, overflow);
                end
                else
                begin
                    want = placement_q.pop_front();
                    if (want.start !== start_column || want.cspan !== used_col_span ||
                        want.rspan !== used_row_span || want.count !== column_count ||
                        want.ovf !== overflow)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("%0t: placement differs", $time);
                            $display("    expected start=%0d cspan=%0d rspan=%0d count=%0d ovf=%0d",
                                     want.start, want.cspan, want.rspan, want.count, want.ovf);
                            $display("    actual   start=%0d cspan=%0d rspan=%0d count=%0d ovf=%0d",
                                     start_column, used_col_span, used_row_span,
                                     column_count, overflow);
                        end
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (place_transaction(command, cell_cols, cell_rows, fresh))
                    placement_q.insert(placement_q.size(), fresh);
            end
            mismatches  <= fail_count;
            outstanding <= placement_q.size();
        end
    end

endmodule

/* test/tb_table_cell_grid_placement.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Table cell grid placement testbench
// Drives directed and random table layouts with random idling on both sides,
// rewrites the row count between phases and reports the checker's verdict.
// ----------------------------------------------------------------------------

module tb_table_cell_grid_placement;
    import tcgp_pkg::*;

    localparam logic [CMD_W-1:0] CMD_IGNORED = 2'd3;
    localparam int ITEM_TARGET      = 1700;
    localparam int QUIET_ITEMS      = 250;
    localparam int PHASE_ITEMS      = 120;
    localparam int DRAIN_CYCLES     = 3 * MAX_COLUMNS_DEF + 20;
    localparam int LONG_HOLD_CYCLES = 400;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        in_valid  = 1'b0;
    logic [1:0]  command   = '0;
    logic [9:0]  cell_cols = '0;
    logic [15:0] cell_rows = '0;
    logic        out_ready = 1'b0;
    logic        in_ready;
    logic        out_valid;
    logic [5:0]  start_column;
    logic [6:0]  used_col_span;
    logic [15:0] used_row_span;
    logic [6:0]  column_count;
    logic        overflow;

    int mismatches;
    int outstanding;
    int items_sent = 0;
    bit quiet      = 1'b0;
    int hold_left  = 0;
    int long_hold  = 0;
    bit long_done  = 1'b0;

    always #2 clk = ~clk;

    table_cell_grid_placement #(
        .MAX_COLUMNS (MAX_COLUMNS_DEF)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .cell_cols     (cell_cols),
        .cell_rows     (cell_rows),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .start_column  (start_column),
        .used_col_span (used_col_span),
        .used_row_span (used_row_span),
        .column_count  (column_count),
        .overflow      (overflow)
    );

    table_cell_grid_placement_checker #(
        .NCOLS (MAX_COLUMNS_DEF)
    ) grid_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .cell_cols     (cell_cols),
        .cell_rows     (cell_rows),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .start_column  (start_column),
        .used_col_span (used_col_span),
        .used_row_span (used_row_span),
        .column_count  (column_count),
        .overflow      (overflow),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    // Result side: random stall bursts, plus one long hold to back up the block.
    always @(negedge clk)
    begin
        if (!long_done && items_sent >= 400)
        begin
            long_done <= 1'b1;
            long_hold <= LONG_HOLD_CYCLES - 1;
            out_ready <= 1'b0;
        end
        else if (long_hold > 0)
        begin
            long_hold <= long_hold - 1;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            hold_left <= $urandom_range(0, 6);
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_item(input logic [1:0] cmd, input logic [9:0] cs, input logic [15:0] rs);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        in_valid  <= 1'b1;
        command   <= cmd;
        cell_cols <= cs;
        cell_rows <= rs;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        if (cmd != CMD_IGNORED) items_sent++;
        if (items_sent >= ITEM_TARGET - QUIET_ITEMS) quiet = 1'b1;
    endtask

    task automatic write_row_total(input logic [15:0] value);
        in_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
        // let a trailing ignored transaction or sweep finish
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_cell();
        logic [9:0]  cs;
        logic [15:0] rs;
        case ($urandom_range(0, 19))
            0:       cs = 10'($urandom_range(0, 1023));
            1, 2:    cs = 10'($urandom_range(9, 64));
            default: cs = 10'($urandom_range(1, 8));
        endcase
        case ($urandom_range(0, 19))
            0:              rs = 16'($urandom());
            1, 2, 3:        rs = '0;
            4, 5:           rs = 16'($urandom_range(5, 40));
            6, 7, 8, 9, 10: rs = 16'($urandom_range(2, 4));
            default:        rs = 16'd1;
        endcase
        send_item(CMD_CELL, cs, rs);
    endtask

    task automatic send_noise();
        if ($urandom_range(0, 1) == 0)
            send_item(CMD_IGNORED, 10'($urandom()), 16'($urandom()));
        else
            send_item(2'($urandom_range(0, 3)), 10'($urandom()), 16'($urandom()));
    endtask

    task automatic run_table(input logic [15:0] rt);
        int rows;
        int cells;
        rows = (rt == 0 || rt > 12) ? $urandom_range(1, 8) : $urandom_range(1, rt + 2);
        for (int r = 0; r < rows; r++)
        begin
            cells = $urandom_range(0, 6);
            for (int c = 0; c < cells; c++)
            begin
                if ($urandom_range(0, 24) == 0) send_noise();
                send_cell();
            end
            // drop the last row end now and then
            if (r != rows - 1 || $urandom_range(0, 9) != 0)
                send_item(CMD_ROW_END, 10'($urandom()), 16'($urandom()));
        end
        send_item(CMD_TABLE_END, 10'($urandom()), 16'($urandom()));
    endtask

    initial
    begin
        logic [15:0] rt;
        int          phase;
        int          phase_start;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // row count still at its reset value: no rows left
        send_item(CMD_CELL, 10'd1, 16'd0);
        send_item(CMD_TABLE_END, 10'd0, 16'd0);

        write_row_total(16'd4);
        send_item(CMD_CELL, 10'd0, 16'd0);
        send_item(CMD_CELL, 10'h3FF, 16'hFFFF);
        send_item(CMD_CELL, 10'd1, 16'd1);
        send_item(CMD_IGNORED, 10'h2AA, 16'h5555);
        send_item(CMD_ROW_END, 10'h155, 16'hAAAA);
        send_item(CMD_CELL, 10'd1000, 16'd2);
        repeat (3) send_item(CMD_ROW_END, 10'd0, 16'd0);
        send_item(CMD_CELL, 10'd2, 16'd0);
        send_item(CMD_CELL, 10'd3, 16'hFFFF);
        send_item(CMD_ROW_END, 10'h3FF, 16'hFFFF);
        send_item(CMD_CELL, 10'd1, 16'd3);
        send_item(CMD_CELL, 10'd1, 16'hAAAA);
        send_item(CMD_TABLE_END, 10'h3FF, 16'hFFFF);
        send_item(CMD_IGNORED, 10'd0, 16'd0);
        send_item(CMD_TABLE_END, 10'd0, 16'd0);

        write_row_total(16'hFFFF);
        send_item(CMD_CELL, 10'd64, 16'd0);
        send_item(CMD_CELL, 10'd1, 16'hFFFE);
        send_item(CMD_TABLE_END, 10'd0, 16'd0);

        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            case (phase)
                0:       rt = 16'd0;
                1:       rt = 16'hFFFF;
                2:       rt = 16'd1;
                default: rt = ($urandom_range(0, 4) == 0) ? 16'($urandom())
                                                          : 16'($urandom_range(1, 12));
            endcase
            write_row_total(rt);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS && items_sent < ITEM_TARGET)
                run_table(rt);
            phase++;
        end

        in_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* table_cell_grid_placement.f */
+incdir+sv
sv/tcgp_pkg.sv
sv/tcgp_ram.sv
sv/tcgp_ctrl.sv
sv/tcgp_dp.sv
sv/table_cell_grid_placement.sv
test/table_cell_grid_placement_checker.sv
test/tb_table_cell_grid_placement.sv
